// ----- sv/tcpq_pkg.sv -----
// Shared types and constants of the three-class priority queue.
package tcpq_pkg;

  localparam int NumCls = 3;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [7:0] CAT_ADMIN   = 8'h41;
  localparam logic [7:0] CAT_FACULTY = 8'h46;
  localparam logic [7:0] CAT_STUDENT = 8'h53;

  localparam logic [1:0] CLS_ADMIN   = 2'd0;
  localparam logic [1:0] CLS_FACULTY = 2'd1;
  localparam logic [1:0] CLS_STUDENT = 2'd2;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [1:0] cls;
    logic       pending;
  } res_t;

endpackage

// ----- sv/tcpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/three_class_priority_queue.sv -----
// Three FIFO job queues (admin, faculty, student) with strict-priority dequeue.
//
// Input channel (in_valid_i / in_stall_o): op_i = 0 enqueues job_data_i to the
// queue named by category_i ('A', 'F', 'S'); op_i = 1 dequeues the head of the
// highest-priority non-empty queue. Every word gives exactly one result word on
// the output channel (out_valid_o / out_stall_i) with status, served job, class
// served and the pending flag after the operation.
//
// Results pass the read stage (s1) and the output register. Throughput: one word
// per cycle unless out_stall_i backs up; head, tail and count live in flops and
// the job store is one RAM with one write and one registered read port, so a
// push and a pop each take a single RAM access in the cycle of acceptance.
//
// Reset clears all heads, tails, counts and the pending flag; the job store is
// not cleared (only written entries are ever read). No clearing pass is needed.
//
// When out_stall_i is held, the result stays on the outputs, one more word can
// sit in the read stage, and then in_stall_o rises until the output drains.
module three_class_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int JOB_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  category_i,
  input  logic [31:0] job_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] served_job_o,
  output logic [1:0]  served_class_o,
  output logic        pending_o
);

  localparam int NumCls = tcpq_pkg::NumCls;
  localparam int StoreW = (JOB_WIDTH < 32) ? JOB_WIDTH : 32;
  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int MemD   = NumCls * QUEUE_DEPTH;
  localparam int AddrW  = $clog2(MemD);

  logic [PtrW-1:0] head_q [NumCls];
  logic [PtrW-1:0] head_d [NumCls];
  logic [PtrW-1:0] tail_q [NumCls];
  logic [PtrW-1:0] tail_d [NumCls];
  logic [CntW-1:0] count_q [NumCls];
  logic [CntW-1:0] count_d [NumCls];
  logic            pending_q, pending_d;

  logic            s1_valid_q, s1_valid_d;
  tcpq_pkg::res_t  s1_q, s1_d;

  logic            out_valid_q;
  tcpq_pkg::res_t  out_q;
  logic [31:0]     out_job_q;

  logic              accept, advance;
  logic              enq_known;
  logic [1:0]        enq_cls, deq_cls;
  logic              deq_any;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [StoreW-1:0] ram_rdata;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    enq_known = 1'b1;
    case (category_i)
      tcpq_pkg::CAT_ADMIN:   enq_cls = tcpq_pkg::CLS_ADMIN;
      tcpq_pkg::CAT_FACULTY: enq_cls = tcpq_pkg::CLS_FACULTY;
      tcpq_pkg::CAT_STUDENT: enq_cls = tcpq_pkg::CLS_STUDENT;
      default: begin
        enq_cls   = tcpq_pkg::CLS_ADMIN;
        enq_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    deq_any = 1'b1;
    if (count_q[0] != '0) begin
      deq_cls = tcpq_pkg::CLS_ADMIN;
    end else if (count_q[1] != '0) begin
      deq_cls = tcpq_pkg::CLS_FACULTY;
    end else if (count_q[2] != '0) begin
      deq_cls = tcpq_pkg::CLS_STUDENT;
    end else begin
      deq_cls = tcpq_pkg::CLS_ADMIN;
      deq_any = 1'b0;
    end
  end

  assign ram_waddr = AddrW'(enq_cls) * AddrW'(QUEUE_DEPTH) + AddrW'(tail_q[enq_cls]);
  assign ram_raddr = AddrW'(deq_cls) * AddrW'(QUEUE_DEPTH) + AddrW'(head_q[deq_cls]);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    pending_d = pending_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    s1_d      = s1_q;
    if (accept) begin
      s1_d.cls = tcpq_pkg::CLS_ADMIN;
      if (op_i == tcpq_pkg::OP_ENQ) begin
        pending_d = 1'b1;
        if (!enq_known) begin
          s1_d.status = tcpq_pkg::ST_UNKNOWN;
        end else if (count_q[enq_cls] == CntW'(QUEUE_DEPTH)) begin
          s1_d.status = tcpq_pkg::ST_FULL;
        end else begin
          ram_we           = 1'b1;
          tail_d[enq_cls]  = (tail_q[enq_cls] == PtrW'(QUEUE_DEPTH - 1)) ? '0
                             : tail_q[enq_cls] + PtrW'(1);
          count_d[enq_cls] = count_q[enq_cls] + CntW'(1);
          s1_d.status      = tcpq_pkg::ST_ENQUEUED;
        end
      end else begin
        if (!deq_any) begin
          pending_d   = 1'b0;
          s1_d.status = tcpq_pkg::ST_EMPTY;
        end else begin
          ram_re           = 1'b1;
          head_d[deq_cls]  = (head_q[deq_cls] == PtrW'(QUEUE_DEPTH - 1)) ? '0
                             : head_q[deq_cls] + PtrW'(1);
          count_d[deq_cls] = count_q[deq_cls] - CntW'(1);
          s1_d.status      = tcpq_pkg::ST_SERVED;
          s1_d.cls         = deq_cls;
        end
      end
      s1_d.pending = pending_d;
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  tcpq_ram #(
    .WIDTH(StoreW),
    .DEPTH(MemD)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(job_data_i[StoreW-1:0]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCls; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
      pending_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      pending_q  <= pending_d;
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (advance && s1_valid_q) begin
      out_q     <= s1_q;
      out_job_q <= (s1_q.status == tcpq_pkg::ST_SERVED) ? 32'(ram_rdata) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign served_job_o   = out_job_q;
  assign served_class_o = out_q.cls;
  assign pending_o      = out_q.pending;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[0] <= CntW'(QUEUE_DEPTH) && count_q[1] <= CntW'(QUEUE_DEPTH) &&
    count_q[2] <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_served : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == tcpq_pkg::OP_DEQ && deq_any
    |=> s1_valid_q && s1_q.status == tcpq_pkg::ST_SERVED)
    else $error("pop of non-empty queue not served");

  a_enq_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tcpq_pkg::ST_ENQUEUED || status_o == tcpq_pkg::ST_FULL ||
    status_o == tcpq_pkg::ST_UNKNOWN) |-> pending_o)
    else $error("enqueue result without pending flag");

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for the three-class priority queue: in-bench model plus directed and random traffic.
module testbench;

  localparam int QDEPTH      = 16;
  localparam int RAND_WORDS  = 1600;
  localparam int QUIET_WORDS = 200;
  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    tcpq_pkg::status_e status;
    logic [31:0]       job;
    logic [1:0]        cls;
    logic              pending;
  } outcome_t;

  class PrioQueueScoreboard;
    logic [31:0] job_store [tcpq_pkg::NumCls][QDEPTH];
    logic [3:0]  head_idx [tcpq_pkg::NumCls];
    logic [3:0]  tail_idx [tcpq_pkg::NumCls];
    logic [4:0]  fill [tcpq_pkg::NumCls];
    logic        pend_flag;
    outcome_t    awaited [$];
    int          mismatches;
    int          status_seen [5];

    function new();
      for (int k = 0; k < tcpq_pkg::NumCls; k++) begin
        head_idx[k] = '0;
        tail_idx[k] = '0;
        fill[k]     = '0;
      end
      for (int s = 0; s < 5; s++) status_seen[s] = 0;
      pend_flag  = 1'b0;
      mismatches = 0;
    endfunction

    function int awaited_count();
      return awaited.size();
    endfunction

    // accepted input word: advance the queue state and store the outcome
    function void note_word(logic op, logic [7:0] cat, logic [31:0] job);
      outcome_t e;
      int       c;
      e = '0;
      c = -1;
      if (op == tcpq_pkg::OP_ENQ) begin
        pend_flag = 1'b1;
        case (cat)
          tcpq_pkg::CAT_ADMIN:   c = tcpq_pkg::CLS_ADMIN;
          tcpq_pkg::CAT_FACULTY: c = tcpq_pkg::CLS_FACULTY;
          tcpq_pkg::CAT_STUDENT: c = tcpq_pkg::CLS_STUDENT;
          default:               c = -1;
        endcase
        if (c < 0) begin
          e.status = tcpq_pkg::ST_UNKNOWN;
        end else if (fill[c] == QDEPTH) begin
          e.status = tcpq_pkg::ST_FULL;
        end else begin
          job_store[c][tail_idx[c]] = job;
          tail_idx[c] = (tail_idx[c] == QDEPTH - 1) ? '0 : tail_idx[c] + 1'b1;
          fill[c]     = fill[c] + 1'b1;
          e.status    = tcpq_pkg::ST_ENQUEUED;
        end
      end else begin
        for (int k = 0; k < tcpq_pkg::NumCls; k++) begin
          if (c < 0 && fill[k] != 0) c = k;
        end
        if (c < 0) begin
          pend_flag = 1'b0;
          e.status  = tcpq_pkg::ST_EMPTY;
        end else begin
          e.job       = job_store[c][head_idx[c]];
          head_idx[c] = (head_idx[c] == QDEPTH - 1) ? '0 : head_idx[c] + 1'b1;
          fill[c]     = fill[c] - 1'b1;
          e.cls       = c[1:0];
          e.status    = tcpq_pkg::ST_SERVED;
        end
      end
      e.pending = pend_flag;
      awaited.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, wanted %h", what, got, want);
      mismatches++;
    endtask

    task check_word(logic [2:0] status, logic [31:0] job, logic [1:0] cls, logic pending);
      outcome_t e;
      if (awaited.size() == 0) begin
        report_mismatch("unrequested result, status", 32'(status), 32'h0);
      end else begin
        e = awaited.pop_front();
        status_seen[e.status]++;
        if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
        if (job !== e.job) report_mismatch("served_job", job, e.job);
        if (cls !== e.cls) report_mismatch("served_class", 32'(cls), 32'(e.cls));
        if (pending !== e.pending) report_mismatch("pending", 32'(pending), 32'(e.pending));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [7:0]  category_i;
  logic [31:0] job_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] served_job_o;
  logic [1:0]  served_class_o;
  logic        pending_o;

  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        quiet;
  int          stuck_cycles = 0;

  PrioQueueScoreboard sb = new();

  three_class_priority_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .category_i     (category_i),
    .job_data_i     (job_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .served_job_o   (served_job_o),
    .served_class_o (served_class_o),
    .pending_o      (pending_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(status_o, served_job_o, served_class_o, pending_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic op, input logic [7:0] cat, input logic [31:0] job);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    category_i <= cat;
    job_data_i <= job;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(op, cat, job);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.awaited_count() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  cat_bytes [3];
    logic        op;
    logic [7:0]  cat;
    int          sent;
    int          phase_len;
    int          enq_pct;
    int          fav;
    int          pick;

    cat_bytes    = '{tcpq_pkg::CAT_ADMIN, tcpq_pkg::CAT_FACULTY, tcpq_pkg::CAT_STUDENT};
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = tcpq_pkg::OP_ENQ;
    category_i   = '0;
    job_data_i   = '0;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    quiet        = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty dequeues, bad categories, priority order, job extremes
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'h0);
    send_word(tcpq_pkg::OP_ENQ, 8'h00, 32'h0);
    send_word(tcpq_pkg::OP_ENQ, 8'hFF, 32'hFFFF_FFFF);
    send_word(tcpq_pkg::OP_DEQ, 8'hFF, 32'hFFFF_FFFF);
    send_word(tcpq_pkg::OP_ENQ, 8'h61, 32'h1234_5678);
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'h0);
    send_word(tcpq_pkg::OP_ENQ, tcpq_pkg::CAT_STUDENT, 32'h0);
    send_word(tcpq_pkg::OP_ENQ, tcpq_pkg::CAT_STUDENT, 32'hFFFF_FFFF);
    send_word(tcpq_pkg::OP_ENQ, tcpq_pkg::CAT_FACULTY, 32'hA5A5_A5A5);
    send_word(tcpq_pkg::OP_ENQ, tcpq_pkg::CAT_ADMIN, 32'h5A5A_5A5A);
    send_word(tcpq_pkg::OP_DEQ, tcpq_pkg::CAT_ADMIN, 32'h0);
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'h0);
    send_word(tcpq_pkg::OP_ENQ, tcpq_pkg::CAT_ADMIN, 32'h0000_0001);
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'hFFFF_FFFF);
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'h0);
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'h0);
    send_word(tcpq_pkg::OP_DEQ, 8'h00, 32'h0);
    drain_results();

    // random phases: fill-heavy, balanced and drain-heavy traffic
    sent = 0;
    while (sent < RAND_WORDS) begin
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 20;
      endcase
      fav        = $urandom_range(0, 2);
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      if (RAND_WORDS - sent <= QUIET_WORDS) begin
        quiet      = 1'b1;
        tx_idle_on = 1'b0;
      end
      for (int i = 0; i < phase_len && sent < RAND_WORDS; i++) begin
        op   = ($urandom_range(0, 99) < enq_pct) ? tcpq_pkg::OP_ENQ : tcpq_pkg::OP_DEQ;
        pick = $urandom_range(0, 99);
        if (pick < 10) cat = 8'($urandom_range(0, 255));
        else if (pick < 55) cat = cat_bytes[fav];
        else cat = cat_bytes[$urandom_range(0, 2)];
        send_word(op, cat, $urandom());
        sent++;
      end
      if (!quiet && $urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.awaited_count() != 0) sb.report_mismatch("results never seen", sb.awaited_count(), 0);

    $display("Checked %0d words: %0d queued, %0d served, %0d dequeues on empty,",
             sb.status_seen[tcpq_pkg::ST_ENQUEUED] + sb.status_seen[tcpq_pkg::ST_SERVED] +
             sb.status_seen[tcpq_pkg::ST_EMPTY] + sb.status_seen[tcpq_pkg::ST_FULL] +
             sb.status_seen[tcpq_pkg::ST_UNKNOWN],
             sb.status_seen[tcpq_pkg::ST_ENQUEUED], sb.status_seen[tcpq_pkg::ST_SERVED],
             sb.status_seen[tcpq_pkg::ST_EMPTY]);
    $display("  %0d drops on a full queue, %0d drops on a bad category.",
             sb.status_seen[tcpq_pkg::ST_FULL], sb.status_seen[tcpq_pkg::ST_UNKNOWN]);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- three_class_priority_queue.f -----
sv/tcpq_pkg.sv
sv/tcpq_ram.sv
sv/three_class_priority_queue.sv
verif/testbench.sv
